@@ src/fcc_pkg.sv @@
package fcc_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int CODE_W      = 5;
   localparam int NUM_CH      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_CH0_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CH0_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CH1_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CH1_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CH2_HIGH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CH2_LOW  = 3'd5;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CODE_W-1:0]      code_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   typedef struct packed {
      sample_type sample_ch0;
      sample_type sample_ch1;
      sample_type sample_ch2;
   } req_type;

   typedef struct packed {
      sample_type avg_ch0;
      sample_type avg_ch1;
      sample_type avg_ch2;
      code_type   chord_code;
      logic       key_valid;
      code_type   key_code;
   } rsp_type;

endpackage

@@ src/flex_chord_key_capture_top.sv @@
// channel | direction | beat
// req_*   | in        | three flex samples (req_type)
// rsp_*   | out       | three averages, chord code, key (rsp_type)
// csr_*   | in        | threshold register write: index + 10-bit data
//
// One req beat per cycle sustained while the queue has room; the per-beat running-total update in the
// front is the only recurrence on the input side.
// rsp_valid rises once a taken req beat has passed the queue, avg_a_ff (divide) and rsp_data_ff (classify).
// A two-entry queue sits between front and back; req_ready drops only when it is full.
// Synchronous reset clears history, totals and capture state and reloads the
// default thresholds.
// csr_ready is always high.
module flex_chord_key_capture_top
   import fcc_pkg::*;
#(
   parameter int AVG_DEPTH = 10,
   parameter int CAPTURE_TICKS = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_data
);

   localparam int TOT_W = SAMPLE_BITS + $clog2(AVG_DEPTH);
   localparam int Q_W   = NUM_CH * TOT_W;

   logic           push_valid, push_ready;
   logic [Q_W-1:0] push_data;
   logic           pop_valid, pop_ready;
   logic [Q_W-1:0] pop_data;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;

   fcc_front #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fcc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fcc_back #(
      .AVG_DEPTH     (AVG_DEPTH),
      .CAPTURE_TICKS (CAPTURE_TICKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/fcc_queue.sv @@
module fcc_queue
   import fcc_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/fcc_front.sv @@
module fcc_front
   import fcc_pkg::*;
#(
   parameter int AVG_DEPTH = 10,
   localparam int TOT_W = SAMPLE_BITS + $clog2(AVG_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  req_type                 req_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic [NUM_CH*TOT_W-1:0] push_data
);

   sample_type             hist_ff [NUM_CH][AVG_DEPTH];
   logic [TOT_W-1:0]       tot_ff [NUM_CH];
   logic [TOT_W-1:0]       tot_in [NUM_CH];
   sample_type             smp [NUM_CH];
   logic                   accept;

   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid;

   always_comb begin
      smp[0] = req_data.sample_ch0;
      smp[1] = req_data.sample_ch1;
      smp[2] = req_data.sample_ch2;
      for (int c = 0; c < NUM_CH; c++) begin
         // oldest sample drops out of the window as the new one enters
         tot_in[c] = tot_ff[c] - TOT_W'(hist_ff[c][AVG_DEPTH-1]) + TOT_W'(smp[c]);
         push_data[c*TOT_W +: TOT_W] = tot_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            tot_ff[c] <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
               hist_ff[c][i] <= '0;
            end
         end
      end else if (accept) begin
         for (int c = 0; c < NUM_CH; c++) begin
            tot_ff[c]     <= tot_in[c];
            hist_ff[c][0] <= smp[c];
            for (int i = 1; i < AVG_DEPTH; i++) begin
               hist_ff[c][i] <= hist_ff[c][i-1];
            end
         end
      end
   end

endmodule

@@ src/fcc_back.sv @@
module fcc_back
   import fcc_pkg::*;
#(
   parameter int AVG_DEPTH = 10,
   parameter int CAPTURE_TICKS = 18,
   localparam int TOT_W = SAMPLE_BITS + $clog2(AVG_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [NUM_CH*TOT_W-1:0] pop_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  csr_idx_type             csr_index,
   input  csr_data_type            csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data
);

   // total / AVG_DEPTH as multiply by rounded-up reciprocal; exact over the total's range
   localparam int     DIV_SH  = TOT_W + $clog2(AVG_DEPTH);
   localparam int     PROD_W  = TOT_W + DIV_SH;
   localparam longint DIV_M   = ((longint'(1) << DIV_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam int     WIN_W   = $clog2(CAPTURE_TICKS + 1);
   localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(CAPTURE_TICKS);

   localparam logic [1:0] LEVEL_STRAIGHT = 2'd0;
   localparam logic [1:0] LEVEL_HALF     = 2'd1;
   localparam logic [1:0] LEVEL_FULL     = 2'd2;

   sample_type        high_ff [NUM_CH];
   sample_type        low_ff [NUM_CH];

   logic [PROD_W-1:0] prod [NUM_CH];
   sample_type        avg_a_ff [NUM_CH];
   sample_type        avg_a_in [NUM_CH];
   logic              a_valid_ff, a_valid_in;
   logic              a_adv, a_load;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_ready, fire;

   logic [1:0]        lvl [NUM_CH];
   code_type          code;

   logic              zero_seen_ff, zero_seen_in;
   logic              capturing_ff, capturing_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   code_type          peak_ff, peak_in;
   logic              emit;
   code_type          key;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign a_adv     = !a_valid_ff || out_ready;
   assign pop_ready = a_adv;
   assign a_load    = a_adv && pop_valid;
   assign fire      = a_valid_ff && out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c]     = PROD_W'(pop_data[c*TOT_W +: TOT_W]) * PROD_W'(DIV_M);
         avg_a_in[c] = prod[c][DIV_SH +: SAMPLE_BITS];
      end
      a_valid_in = a_adv ? pop_valid : a_valid_ff;
   end

   // later tests override earlier ones, so avg equal to high lands on the middle level
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         lvl[c] = LEVEL_STRAIGHT;
         if (avg_a_ff[c] <= high_ff[c] && avg_a_ff[c] >= low_ff[c]) begin
            lvl[c] = LEVEL_HALF;
         end
         if (avg_a_ff[c] <= low_ff[c]) begin
            lvl[c] = LEVEL_FULL;
         end
      end
      code = CODE_W'(lvl[0]) + CODE_W'(lvl[1]) * CODE_W'(3) + CODE_W'(lvl[2]) * CODE_W'(9);
   end

   always_comb begin
      zero_seen_in = zero_seen_ff;
      capturing_in = capturing_ff;
      win_in       = win_ff;
      peak_in      = peak_ff;
      emit         = 1'b0;
      key          = '0;
      if (code == '0 && !zero_seen_ff) begin
         zero_seen_in = 1'b1;
         win_in       = '0;
      end
      if (code != '0 && zero_seen_in) begin
         capturing_in = 1'b1;
      end
      if (capturing_in && win_in <= WIN_LAST) begin
         if (code != '0 && code > peak_in) begin
            peak_in = code;
         end
         if (win_in >= WIN_LAST) begin
            emit         = 1'b1;
            key          = peak_in;
            peak_in      = '0;
            capturing_in = 1'b0;
            zero_seen_in = 1'b0;
         end else begin
            win_in = win_in + 1'b1;
         end
      end
      rsp_data_in.avg_ch0    = avg_a_ff[0];
      rsp_data_in.avg_ch1    = avg_a_ff[1];
      rsp_data_in.avg_ch2    = avg_a_ff[2];
      rsp_data_in.chord_code = code;
      rsp_data_in.key_valid  = emit;
      rsp_data_in.key_code   = key;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zero_seen_ff <= 1'b1;
         capturing_ff <= 1'b0;
         win_ff       <= '0;
         peak_ff      <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            zero_seen_ff <= zero_seen_in;
            capturing_ff <= capturing_in;
            win_ff       <= win_in;
            peak_ff      <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         avg_a_ff <= avg_a_in;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff[0] <= 10'd650;
         low_ff[0]  <= 10'd400;
         high_ff[1] <= 10'd850;
         low_ff[1]  <= 10'd600;
         high_ff[2] <= 10'd750;
         low_ff[2]  <= 10'd500;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CH0_HIGH: high_ff[0] <= csr_data;
            CSR_CH0_LOW:  low_ff[0]  <= csr_data;
            CSR_CH1_HIGH: high_ff[1] <= csr_data;
            CSR_CH1_LOW:  low_ff[1]  <= csr_data;
            CSR_CH2_HIGH: high_ff[2] <= csr_data;
            CSR_CH2_LOW:  low_ff[2]  <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule
